### rtl/atrr_pkg.sv
// Shared types and constants for the AT response recognizer.
// No dependencies; imported by atrr_match and at_response_recognizer.
package atrr_pkg;

  localparam int HIST_DEPTH = 12;
  localparam int LEN_W      = 4;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(HIST_DEPTH);

  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;

  // Oldest byte in the MSBs, newest in the LSBs.
  localparam logic [15:0] PAT_CRLF  = {CHAR_CR, CHAR_LF};
  localparam logic [31:0] PAT_OK    = {"OK", CHAR_CR, CHAR_LF};
  localparam logic [55:0] PAT_ERROR = {"ERROR", CHAR_CR, CHAR_LF};
  localparam logic [95:0] PAT_NOCAR = {"NO CARRIER", CHAR_CR, CHAR_LF};
  localparam logic [71:0] PAT_CME   = "CME ERROR";

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_OK         = 3'd1,
    ST_ERROR      = 3'd2,
    ST_NO_CARRIER = 3'd3,
    ST_CME        = 3'd4
  } status_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_CMD  = 1'b1
  } req_t;

  // Byte history, index 0 is the newest byte.
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  typedef struct packed {
    logic crlf;
    logic ok;
    logic error;
    logic nocar;
    logic cme;
  } match_t;

endpackage

### rtl/atrr_match.sv
// Tail pattern compare against the byte history of the current line.
// Depends on atrr_pkg.
module atrr_match (
  input  atrr_pkg::hist_t             hist,
  input  logic [atrr_pkg::LEN_W-1:0]  len,
  output atrr_pkg::match_t            hit
);
  import atrr_pkg::*;

  // A pattern only counts once the line holds at least that many bytes.
  always_comb begin
    hit.crlf  = (len >= LEN_W'(2))  && (hist[1:0]  == PAT_CRLF);
    hit.ok    = (len >= LEN_W'(4))  && (hist[3:0]  == PAT_OK);
    hit.error = (len >= LEN_W'(7))  && (hist[6:0]  == PAT_ERROR);
    hit.nocar = (len >= LEN_W'(12)) && (hist[11:0] == PAT_NOCAR);
    hit.cme   = (len >= LEN_W'(9))  && (hist[8:0]  == PAT_CME);
  end

endmodule

### rtl/at_response_recognizer.sv
// AT response recognizer: line tracking, echo detection and final result decode.
// Each input transfer passes through the input register, then the result register.
// Throughput: one item per cycle while out_stall does not hold the pipeline; each item yields exactly one result.
// Reset (rst_n low, synchronous): idle, status OK, empty line, both stages empty.
// Depends on atrr_pkg and atrr_match.
module at_response_recognizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_ready_status,
  output logic       out_in_response,
  output logic       out_response_done,
  output logic       out_urc_line
);
  import atrr_pkg::*;

  // Input stage
  logic       s1_valid_r;
  logic       s1_req_r;
  logic [7:0] s1_byte_r;

  // Line / response state
  logic             mode_r, mode_nxt;
  status_t          status_r, status_nxt;
  hist_t            hist_r, hist_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, len_inc;
  logic             first_a_r, first_a_nxt;
  logic             at_r, at_nxt;
  logic             text_r, text_nxt;
  logic             cme_r, cme_nxt;

  // Result stage
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic       out_resp_r;
  logic       out_done_r, done_nxt;
  logic       out_urc_r, urc_nxt;

  logic       s2_ready;
  logic       fire2;
  logic       is_space;
  logic       clear_line;
  match_t     hit;

  assign s2_ready = !out_valid_r || !out_stall;
  assign fire2    = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
  end

  assign hist_nxt = {hist_r[HIST_DEPTH-2:0], s1_byte_r};
  assign len_inc  = (len_r < LEN_MAX) ? len_r + LEN_W'(1) : len_r;
  assign is_space = (s1_byte_r == CHAR_SP) ||
                    ((s1_byte_r >= CHAR_HT) && (s1_byte_r <= CHAR_CR));

  atrr_match u_match (
    .hist (hist_nxt),
    .len  (len_inc),
    .hit  (hit)
  );

  always_comb begin
    mode_nxt    = mode_r;
    status_nxt  = status_r;
    len_nxt     = len_r;
    first_a_nxt = first_a_r;
    at_nxt      = at_r;
    text_nxt    = text_r;
    cme_nxt     = cme_r;
    done_nxt    = 1'b0;
    urc_nxt     = 1'b0;
    clear_line  = 1'b0;
    if (s1_req_r == REQ_CMD) begin
      mode_nxt   = 1'b0;
      status_nxt = ST_PENDING;
    end else begin
      len_nxt = len_inc;
      if (len_r == LEN_W'(0)) begin
        first_a_nxt = (s1_byte_r == CHAR_A);
      end else if (len_r == LEN_W'(1)) begin
        at_nxt = first_a_r && (s1_byte_r == CHAR_T);
      end
      if (!is_space) begin
        text_nxt = 1'b1;
      end
      if (hit.cme) begin
        cme_nxt = 1'b1;
      end
      if (!mode_r) begin
        if (hit.crlf) begin
          // echo of our own command opens the response; other text is unsolicited
          if (at_nxt) begin
            mode_nxt = 1'b1;
          end else if (text_nxt) begin
            urc_nxt = 1'b1;
          end
          clear_line = 1'b1;
        end
      end else if (s1_byte_r == CHAR_LF) begin
        priority if (hit.ok) begin
          status_nxt = ST_OK;
        end else if (hit.error) begin
          status_nxt = ST_ERROR;
        end else if (hit.nocar) begin
          status_nxt = ST_NO_CARRIER;
        end else if (cme_nxt) begin
          status_nxt = ST_CME;
        end
        // a stale nonzero status also ends the response
        if (status_nxt != ST_PENDING) begin
          mode_nxt   = 1'b0;
          done_nxt   = 1'b1;
          clear_line = 1'b1;
        end
      end
      if (clear_line) begin
        len_nxt     = '0;
        first_a_nxt = 1'b0;
        at_nxt      = 1'b0;
        text_nxt    = 1'b0;
        cme_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      status_r  <= ST_OK;
      hist_r    <= '0;
      len_r     <= '0;
      first_a_r <= 1'b0;
      at_r      <= 1'b0;
      text_r    <= 1'b0;
      cme_r     <= 1'b0;
    end else if (fire2) begin
      mode_r    <= mode_nxt;
      status_r  <= status_nxt;
      if (s1_req_r == REQ_BYTE) begin
        hist_r <= hist_nxt;
      end
      len_r     <= len_nxt;
      first_a_r <= first_a_nxt;
      at_r      <= at_nxt;
      text_r    <= text_nxt;
      cme_r     <= cme_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      out_status_r <= status_nxt;
      out_resp_r   <= mode_nxt;
      out_done_r   <= done_nxt;
      out_urc_r    <= urc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ready_status  = out_status_r;
  assign out_in_response   = out_resp_r;
  assign out_response_done = out_done_r;
  assign out_urc_line      = out_urc_r;

`ifndef SYNTHESIS
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_resp_r && (out_status_r != ST_PENDING))
    else $error("response_done with response still open or status pending");

  a_done_urc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_urc_r))
    else $error("response_done and urc_line on the same result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("line length beyond history depth");

  a_cmd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire2 && (s1_req_r == REQ_CMD) |=> (status_r == ST_PENDING) && !mode_r)
    else $error("command transfer did not clear status and mode");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty pipeline stage");
`endif

endmodule

### verif/atrr_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the AT response recognizer: watches both channels, tracks line state
// on each input transfer and compares every result transfer. Depends on atrr_pkg.
module atrr_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_ready_status,
  input  logic       out_in_response,
  input  logic       out_response_done,
  input  logic       out_urc_line,
  output int         fail_count,
  output int         pending
);
  import atrr_pkg::*;

  typedef struct {
    status_t status;
    logic    in_resp;
    logic    done;
    logic    urc;
  } line_result_t;

  line_result_t predicted_q[$];

  // Line tracking state; hist[0] is the newest byte.
  logic             resp_mode;
  status_t          status;
  logic [7:0]       hist [HIST_DEPTH];
  logic [LEN_W-1:0] line_len;
  logic             first_a;
  logic             at_start;
  logic             has_text;
  logic             cme;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c >= CHAR_HT && c <= CHAR_CR);
  endfunction

  // Pattern is packed oldest byte first, so byte k from the newest sits at bits 8k.
  function automatic logic tail_matches(input logic [95:0] pat, input int n);
    if (int'(line_len) < n) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (hist[k] != pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    line_len = '0;
    first_a  = 1'b0;
    at_start = 1'b0;
    has_text = 1'b0;
    cme      = 1'b0;
  endtask

  task automatic reset_line_state();
    resp_mode = 1'b0;
    status    = ST_OK;
    for (int k = 0; k < HIST_DEPTH; k++) hist[k] = 8'h00;
    clear_line();
  endtask

  task automatic advance_line_state(input logic req, input logic [7:0] c,
                                    output line_result_t r);
    logic done;
    logic urc;
    done = 1'b0;
    urc  = 1'b0;
    if (req == REQ_CMD) begin
      resp_mode = 1'b0;
      status    = ST_PENDING;
    end else begin
      for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = c;
      if (line_len == 0) first_a = (c == CHAR_A);
      else if (line_len == 1) at_start = first_a && (c == CHAR_T);
      if (line_len < LEN_MAX) line_len = line_len + 1'b1;
      if (!is_blank(c)) has_text = 1'b1;
      if (tail_matches(96'(PAT_CME), 9)) cme = 1'b1;
      if (!resp_mode) begin
        if (tail_matches(96'(PAT_CRLF), 2)) begin
          if (at_start) resp_mode = 1'b1;
          else if (has_text) urc = 1'b1;
          clear_line();
        end
      end else if (c == CHAR_LF) begin
        if (tail_matches(96'(PAT_OK), 4)) status = ST_OK;
        else if (tail_matches(96'(PAT_ERROR), 7)) status = ST_ERROR;
        else if (tail_matches(PAT_NOCAR, 12)) status = ST_NO_CARRIER;
        else if (cme) status = ST_CME;
        // a stale nonzero status also closes the response here
        if (status != ST_PENDING) begin
          resp_mode = 1'b0;
          clear_line();
          done = 1'b1;
        end
      end
    end
    r.status  = status;
    r.in_resp = resp_mode;
    r.done    = done;
    r.urc     = urc;
  endtask

  task automatic compare_field(input string name, input int expv, input int gotv);
    if (expv != gotv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    line_result_t r;
    if (!rst_n) begin
      reset_line_state();
      predicted_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %0d", $time,
                   out_ready_status);
          fail_count++;
        end else begin
          r = predicted_q.pop_front();
          compare_field("ready_status", int'(r.status), int'(out_ready_status));
          compare_field("in_response", int'(r.in_resp), int'(out_in_response));
          compare_field("response_done", int'(r.done), int'(out_response_done));
          compare_field("urc_line", int'(r.urc), int'(out_urc_line));
        end
      end
      if (in_valid && !in_stall) begin
        advance_line_state(in_req_type, in_rx_byte, r);
        predicted_q.push_back(r);
      end
    end
    pending = predicted_q.size();
  end

endmodule

### verif/tb_at_response_recognizer.sv
`timescale 1ns / 100ps
// Top of the AT response recognizer testbench: clock, reset, byte and command stimulus,
// receiver stall pattern and verdict. Depends on atrr_pkg and atrr_result_checker.
module tb_at_response_recognizer;
  import atrr_pkg::*;

  localparam int NUM_ITEMS   = 650;
  localparam int CYCLE_LIMIT = 300000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_ready_status;
  logic       out_in_response;
  logic       out_response_done;
  logic       out_urc_line;

  int fail_count;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 1;

  int stall_style = 0;
  int stall_left  = 0;

  at_response_recognizer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ready_status  (out_ready_status),
    .out_in_response   (out_in_response),
    .out_response_done (out_response_done),
    .out_urc_line      (out_urc_line)
  );

  atrr_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ready_status  (out_ready_status),
    .out_in_response   (out_in_response),
    .out_response_done (out_response_done),
    .out_urc_line      (out_urc_line),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: phases of no stall, light, heavy and long-run stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
    endcase
  end

  task automatic send_byte(input logic req, input logic [7:0] b);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid    <= 1'b0;
        in_rx_byte  <= 8'($urandom_range(0, 255));
        in_req_type <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_cmd();
    send_byte(REQ_CMD, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(REQ_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send_byte(REQ_BYTE, CHAR_CR);
    send_byte(REQ_BYTE, CHAR_LF);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_crlf();
  endtask

  task automatic send_printable(input int n);
    for (int i = 0; i < n; i++) send_byte(REQ_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
  endtask

  // Hold off new transfers until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Command, echo, optional info lines and a final result, with occasional breakage.
  task automatic run_exchange();
    int n;
    if ($urandom_range(0, 9) != 0) send_cmd();
    case ($urandom_range(0, 9))
      0: send_text("AX");
      1: send_text("at");
      default: send_text("AT");
    endcase
    send_printable($urandom_range(0, 14));
    if ($urandom_range(0, 9) != 0) send_crlf();
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        send_crlf();
      end else begin
        send_text("+");
        send_printable($urandom_range(0, 16));
        send_crlf();
      end
    end
    if ($urandom_range(0, 1) == 0) send_crlf();
    case ($urandom_range(0, 6))
      0, 1: send_text("OK");
      2: send_text("ERROR");
      3: send_text("NO CARRIER");
      4: begin
        send_text("+CME ERROR: ");
        for (int i = 0; i < $urandom_range(1, 3); i++)
          send_byte(REQ_BYTE, 8'($urandom_range(8'h30, 8'h39)));
      end
      5: send_printable($urandom_range(0, 12));
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) send_crlf();
  endtask

  // Unsolicited lines, blank lines, raw bytes and stray commands.
  task automatic run_noise();
    int n;
    case ($urandom_range(0, 4))
      0: begin
        send_text("+");
        send_printable($urandom_range(0, 20));
        send_crlf();
      end
      1: begin
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          send_byte(REQ_BYTE,
                    ($urandom_range(0, 1) == 0) ? CHAR_SP : 8'($urandom_range(9, 13)));
        send_crlf();
      end
      2: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) send_byte(REQ_BYTE, 8'($urandom_range(0, 255)));
      end
      3: send_cmd();
      default: begin
        send_printable($urandom_range(13, 24));
        send_crlf();
      end
    endcase
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_BYTE;
    in_rx_byte  = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: command, echo and OK; text lines of 0xFF and NUL; a whitespace-only
    // line; an echo with no command before it, closed by a bare LF with the old status.
    send_cmd();
    send_line("AT");
    send_line("OK");
    send_byte(REQ_BYTE, 8'hFF);
    send_crlf();
    send_byte(REQ_BYTE, CHAR_HT);
    send_byte(REQ_BYTE, 8'h0B);
    send_crlf();
    send_byte(REQ_BYTE, 8'h00);
    send_crlf();
    send_line("AT");
    send_byte(REQ_BYTE, CHAR_LF);
    drain();

    while (items_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) run_exchange();
      else run_noise();
      if ($urandom_range(0, 30) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
